>>> design/gzhc_pkg.sv
// gzhc_pkg: shared types, constants and the byte-wide crc-32 update for the
// gzip member header/trailer checker
// no dependencies
package gzhc_pkg;

   localparam logic [31:0] GZ_CRC_POLY   = 32'hEDB8_8320;
   localparam logic [7:0]  GZ_MAGIC1     = 8'h1F;
   localparam logic [7:0]  GZ_MAGIC2     = 8'h8B;
   localparam logic [7:0]  GZ_DEFLATE    = 8'd8;
   localparam logic [7:0]  GZ_FTEXT      = 8'h01;
   localparam logic [7:0]  GZ_FHCRC      = 8'h02;
   localparam logic [7:0]  GZ_FEXTRA     = 8'h04;
   localparam logic [7:0]  GZ_FNAME      = 8'h08;
   localparam logic [7:0]  GZ_FCOMMENT   = 8'h10;
   localparam logic [7:0]  GZ_FKNOWN     = GZ_FTEXT | GZ_FHCRC | GZ_FEXTRA | GZ_FNAME |
                                           GZ_FCOMMENT;

   // transaction actions
   localparam logic [1:0]  ACT_CONTAINER = 2'd0;
   localparam logic [1:0]  ACT_DATA      = 2'd1;
   localparam logic [1:0]  ACT_BODY_END  = 2'd2;
   localparam logic [1:0]  ACT_EOF       = 2'd3;

   // status codes
   localparam logic [3:0]  ST_BUSY       = 4'd0;
   localparam logic [3:0]  ST_MEMBER_OK  = 4'd1;
   localparam logic [3:0]  ST_BAD_MAGIC  = 4'd2;
   localparam logic [3:0]  ST_BAD_METHOD = 4'd3;
   localparam logic [3:0]  ST_CRC_ERR    = 4'd4;
   localparam logic [3:0]  ST_LEN_ERR    = 4'd5;
   localparam logic [3:0]  ST_EARLY_EOF  = 4'd6;
   localparam logic [3:0]  ST_RSVD_FLAGS = 4'd7;
   localparam logic [3:0]  ST_TRAILING   = 4'd8;

   // parser phases
   localparam logic [3:0]  PH_MAGIC1     = 4'd0;
   localparam logic [3:0]  PH_MAGIC2     = 4'd1;
   localparam logic [3:0]  PH_METHOD     = 4'd2;
   localparam logic [3:0]  PH_FLAGS      = 4'd3;
   localparam logic [3:0]  PH_MTIME      = 4'd4;
   localparam logic [3:0]  PH_XFL        = 4'd5;
   localparam logic [3:0]  PH_OS         = 4'd6;
   localparam logic [3:0]  PH_XLEN       = 4'd7;
   localparam logic [3:0]  PH_EXTRA      = 4'd8;
   localparam logic [3:0]  PH_NAME       = 4'd9;
   localparam logic [3:0]  PH_COMMENT    = 4'd10;
   localparam logic [3:0]  PH_HCRC       = 4'd11;
   localparam logic [3:0]  PH_BODY       = 4'd12;
   localparam logic [3:0]  PH_TRAILER    = 4'd13;

   typedef struct packed {
      logic [3:0]  phase;
      logic [2:0]  byte_index;
      logic [7:0]  flag_bits;
      logic [15:0] extra_remaining;
      logic [31:0] running_crc;
      logic [31:0] output_length;
      logic [31:0] assembled_word;
      logic        member_seen_ok;
      logic        in_error;
   } state_type;

   typedef struct packed {
      logic [3:0]  status;
      logic        mtime_valid;
      logic [31:0] mtime_value;
      logic        name_valid;
      logic [7:0]  name_char;
      logic        out_valid;
      logic [7:0]  out_byte;
   } result_type;

   localparam state_type GZ_STATE_RESET = '0;

   // reflected crc-32 with pre and post inversion, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ GZ_CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

endpackage

>>> design/gzhc_if.sv
// gzhc_req_if / gzhc_rsp_if: valid/ready channels of the gzip member checker
// depends on nothing
interface gzhc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink (input valid, action, data_byte, output ready);
   modport monitor (input valid, ready, action, data_byte);
endinterface

interface gzhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic        mtime_valid;
   logic [31:0] mtime_value;
   logic        name_valid;
   logic [7:0]  name_char;
   logic        out_valid;
   logic [7:0]  out_byte;

   modport source (output valid, status, mtime_valid, mtime_value, name_valid, name_char,
                   out_valid, out_byte, input ready);
   modport sink (input valid, status, mtime_valid, mtime_value, name_valid, name_char,
                 out_valid, out_byte, output ready);
   modport monitor (input valid, ready, status, mtime_valid, mtime_value, name_valid,
                    name_char, out_valid, out_byte);
endinterface

>>> design/gzhc_step.sv
// gzhc_step: next-state and result logic for one transaction of the gzip
// member parser; depends on gzhc_pkg
module gzhc_step import gzhc_pkg::*; (
   input  state_type  state_ff,
   input  logic [1:0] action,
   input  logic [7:0] data_byte,
   output state_type  state_in,
   output result_type rsp_in
);

   // advance to the first optional field enabled at or after the given phase
   function automatic state_type next_field(input state_type s, input logic [3:0] from);
      state_type r;
      r = s;
      r.byte_index = '0;
      if (from <= PH_XLEN && (s.flag_bits & GZ_FEXTRA) != '0) begin
         r.phase = PH_XLEN;
         r.assembled_word = '0;
      end else if (from <= PH_NAME && (s.flag_bits & GZ_FNAME) != '0) begin
         r.phase = PH_NAME;
      end else if (from <= PH_COMMENT && (s.flag_bits & GZ_FCOMMENT) != '0) begin
         r.phase = PH_COMMENT;
      end else if (from <= PH_HCRC && (s.flag_bits & GZ_FHCRC) != '0) begin
         r.phase = PH_HCRC;
      end else begin
         r.phase = PH_BODY;
         r.member_seen_ok = 1'b0;
         r.running_crc = '0;
         r.output_length = '0;
      end
      return r;
   endfunction

   logic [31:0] merged_word;
   logic [15:0] extra_full;
   logic [15:0] extra_dec;

   // byte lands at lane byte_index mod 4
   assign merged_word = state_ff.assembled_word |
                        ({24'd0, data_byte} << {state_ff.byte_index[1:0], 3'b000});
   assign extra_full  = {data_byte, state_ff.extra_remaining[7:0]};
   assign extra_dec   = state_ff.extra_remaining - 16'd1;

   always_comb begin
      state_in = state_ff;
      rsp_in   = '0;
      if (action == ACT_EOF) begin
         if (!state_ff.in_error && state_ff.phase != PH_MAGIC1) begin
            rsp_in.status = state_ff.member_seen_ok ? ST_TRAILING : ST_EARLY_EOF;
         end
         state_in = GZ_STATE_RESET;
      end else if (state_ff.in_error) begin
         state_in = state_ff;
      end else if (action == ACT_DATA) begin
         if (state_ff.phase == PH_BODY) begin
            state_in.running_crc   = crc_byte(state_ff.running_crc, data_byte);
            state_in.output_length = state_ff.output_length + 32'd1;
            rsp_in.out_valid = 1'b1;
            rsp_in.out_byte  = data_byte;
         end
      end else if (action == ACT_BODY_END) begin
         if (state_ff.phase == PH_BODY) begin
            state_in.phase = PH_TRAILER;
            state_in.byte_index = '0;
            state_in.assembled_word = '0;
         end
      end else begin
         unique case (state_ff.phase) inside
            PH_MAGIC1, PH_MAGIC2: begin
               if (data_byte != ((state_ff.phase == PH_MAGIC1) ? GZ_MAGIC1 : GZ_MAGIC2)) begin
                  rsp_in.status = state_ff.member_seen_ok ? ST_TRAILING : ST_BAD_MAGIC;
                  state_in.in_error = 1'b1;
                  state_in.member_seen_ok = 1'b0;
               end else begin
                  state_in.phase = (state_ff.phase == PH_MAGIC1) ? PH_MAGIC2 : PH_METHOD;
               end
            end
            PH_METHOD: begin
               if (data_byte != GZ_DEFLATE) begin
                  rsp_in.status = state_ff.member_seen_ok ? ST_TRAILING : ST_BAD_METHOD;
                  state_in.in_error = 1'b1;
                  state_in.member_seen_ok = 1'b0;
               end else begin
                  state_in.phase = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               state_in.flag_bits = data_byte;
               if ((data_byte & ~GZ_FKNOWN) != '0) begin
                  rsp_in.status = ST_RSVD_FLAGS;
               end
               state_in.phase = PH_MTIME;
               state_in.byte_index = '0;
               state_in.assembled_word = '0;
            end
            PH_MTIME: begin
               state_in.assembled_word = merged_word;
               if (state_ff.byte_index[1:0] == 2'd3) begin
                  rsp_in.mtime_valid = 1'b1;
                  rsp_in.mtime_value = merged_word;
                  state_in.phase = PH_XFL;
                  state_in.byte_index = '0;
               end else begin
                  state_in.byte_index = state_ff.byte_index + 3'd1;
               end
            end
            PH_XFL: begin
               state_in.phase = PH_OS;
            end
            PH_OS: begin
               state_in = next_field(state_ff, PH_XLEN);
            end
            PH_XLEN: begin
               if (state_ff.byte_index == 3'd0) begin
                  state_in.extra_remaining = {8'd0, data_byte};
                  state_in.byte_index = 3'd1;
               end else begin
                  state_in.extra_remaining = extra_full;
                  state_in.byte_index = '0;
                  if (extra_full != '0) begin
                     state_in.phase = PH_EXTRA;
                  end else begin
                     state_in = next_field(state_in, PH_NAME);
                  end
               end
            end
            PH_EXTRA: begin
               state_in.extra_remaining = extra_dec;
               if (extra_dec == '0) begin
                  state_in = next_field(state_in, PH_NAME);
               end
            end
            PH_NAME: begin
               if (data_byte == 8'd0) begin
                  state_in = next_field(state_ff, PH_COMMENT);
               end else begin
                  rsp_in.name_valid = 1'b1;
                  rsp_in.name_char  = data_byte;
               end
            end
            PH_COMMENT: begin
               if (data_byte == 8'd0) begin
                  state_in = next_field(state_ff, PH_HCRC);
               end
            end
            PH_HCRC: begin
               if (state_ff.byte_index == 3'd0) begin
                  state_in.byte_index = 3'd1;
               end else begin
                  state_in.byte_index = '0;
                  state_in.phase = PH_BODY;
                  state_in.member_seen_ok = 1'b0;
                  state_in.running_crc = '0;
                  state_in.output_length = '0;
               end
            end
            PH_TRAILER: begin
               state_in.assembled_word = merged_word;
               if (state_ff.byte_index == 3'd3) begin
                  if (merged_word != state_ff.running_crc) begin
                     rsp_in.status = state_ff.member_seen_ok ? ST_TRAILING : ST_CRC_ERR;
                     state_in.in_error = 1'b1;
                     state_in.member_seen_ok = 1'b0;
                  end else begin
                     state_in.assembled_word = '0;
                     state_in.byte_index = 3'd4;
                  end
               end else if (state_ff.byte_index == 3'd7) begin
                  if (merged_word != state_ff.output_length) begin
                     rsp_in.status = state_ff.member_seen_ok ? ST_TRAILING : ST_LEN_ERR;
                     state_in.in_error = 1'b1;
                     state_in.member_seen_ok = 1'b0;
                  end else begin
                     rsp_in.status = ST_MEMBER_OK;
                     state_in.member_seen_ok = 1'b1;
                     state_in.phase = PH_MAGIC1;
                     state_in.byte_index = '0;
                     state_in.assembled_word = '0;
                  end
               end else begin
                  state_in.byte_index = state_ff.byte_index + 3'd1;
               end
            end
            default: begin
               // body: container bytes belong to the inflate core
               state_in = state_ff;
            end
         endcase
      end
   end

endmodule

>>> design/gzip_member_header_trailer_check.sv
// gzip_member_header_trailer_check: top level of the gzip member checker
// depends on gzhc_pkg, gzhc_req_if, gzhc_rsp_if and gzhc_step
//
// Takes one transaction per clock while results are taken, and returns exactly
// one result transaction for each, in order. A transaction is held in an input
// register, goes through the parser step (header decode, byte-wide crc-32
// update, trailer compare) and moves on into a result register once the result
// side is not stalled. The crc-32 byte update in that single step sets the
// clock period. A waiting result does not block the input register: the block
// keeps accepting until both registers hold an untaken transaction. End of
// input returns the parser to its reset state for a new stream.
module gzip_member_header_trailer_check import gzhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gzhc_req_if.sink    req_chan,
   gzhc_rsp_if.source  rsp_chan
);

   logic       in_valid_ff;
   logic [1:0] in_action_ff;
   logic [7:0] in_byte_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       out_valid_ff;
   result_type out_ff;
   result_type rsp_in;
   logic       advance;
   logic       fire;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_action_ff <= req_chan.action;
         in_byte_ff   <= req_chan.data_byte;
      end
   end

   gzhc_step u_step (
      .state_ff  (state_ff),
      .action    (in_action_ff),
      .data_byte (in_byte_ff),
      .state_in  (state_in),
      .rsp_in    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GZ_STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.mtime_valid = out_ff.mtime_valid;
   assign rsp_chan.mtime_value = out_ff.mtime_value;
   assign rsp_chan.name_valid  = out_ff.name_valid;
   assign rsp_chan.name_char   = out_ff.name_char;
   assign rsp_chan.out_valid   = out_ff.out_valid;
   assign rsp_chan.out_byte    = out_ff.out_byte;

endmodule

>>> design/gzhc_checker.sv
// gzhc_checker: port-level assertions for the gzip member checker, bound to
// the top level; depends on gzhc_pkg
module gzhc_checker import gzhc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic        rsp_mtime_valid,
   input logic [31:0] rsp_mtime_value,
   input logic        rsp_name_valid,
   input logic [7:0]  rsp_name_char,
   input logic        rsp_out_valid,
   input logic [7:0]  rsp_out_byte
);

   // a stalled result transaction stays put
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_status) && $stable(rsp_out_byte) &&
            $stable(rsp_name_char) && $stable(rsp_mtime_value);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // at most one kind of payload per result
   property p_one_payload;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> $onehot0({rsp_mtime_valid, rsp_name_valid, rsp_out_valid});
   endproperty
   a_one_payload: assert property (p_one_payload) else $error("several payload kinds");

   // payload without its flag reads as zero
   property p_zero_fill;
      @(posedge clock) disable iff (reset)
         rsp_valid |->
            (rsp_out_valid || rsp_out_byte == 8'd0) &&
            (rsp_name_valid || rsp_name_char == 8'd0) &&
            (rsp_mtime_valid || rsp_mtime_value == 32'd0);
   endproperty
   a_zero_fill: assert property (p_zero_fill) else $error("stray payload bits");

   // data, name and mtime results carry busy status only
   property p_payload_status;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_out_valid || rsp_name_valid || rsp_mtime_valid) |->
            rsp_status == ST_BUSY;
   endproperty
   a_payload_status: assert property (p_payload_status) else $error("payload with status");

   // never more than the two buffered transactions: ready returns once results drain
   property p_ready_after_drain;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> req_ready;
   endproperty
   a_ready_after_drain: assert property (p_ready_after_drain)
      else $error("input stalled with empty result register");

endmodule

bind gzip_member_header_trailer_check gzhc_checker u_gzhc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_mtime_valid (rsp_chan.mtime_valid),
   .rsp_mtime_value (rsp_chan.mtime_value),
   .rsp_name_valid  (rsp_chan.name_valid),
   .rsp_name_char   (rsp_chan.name_char),
   .rsp_out_valid   (rsp_chan.out_valid),
   .rsp_out_byte    (rsp_chan.out_byte)
);

>>> tb/gzip_member_header_trailer_check_tb.sv
`timescale 1ns / 1ps
// gzip_member_header_trailer_check_tb: drives gzip member streams through the checker and
// compares every result transaction with a parser model kept in this file
// depends on gzhc_pkg, gzhc_req_if, gzhc_rsp_if and gzip_member_header_trailer_check
module gzip_member_header_trailer_check_tb;
   import gzhc_pkg::*;

   localparam int unsigned STREAM_ITEMS   = 1950;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct {
      logic [1:0] action;
      logic [7:0] data_byte;
      bit         hold;
   } stream_item_type;

   typedef enum int {
      FLT_NONE, FLT_MAGIC1, FLT_MAGIC2, FLT_METHOD, FLT_CRC, FLT_LENGTH, FLT_CUT
   } member_fault_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gzhc_req_if req_if ();
   gzhc_rsp_if rsp_if ();

   gzip_member_header_trailer_check dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #4 clock = ~clock;

   stream_item_type stream_items[$];
   stream_item_type member_buf[$];
   result_type      results_due[$];

   logic        req_taken = 1'b0;
   logic        drained = 1'b0;
   int unsigned cyc = 0;
   int unsigned idle_cycles = 0;
   int unsigned err_count = 0;
   int unsigned results_seen = 0;

   wire steady = (cyc >= 800) && (cyc < 1400);

   // parser model state
   logic [3:0]  gz_phase;
   logic [2:0]  gz_idx;
   logic [7:0]  gz_flags;
   logic [15:0] gz_extra_left;
   logic [31:0] gz_crc;
   logic [31:0] gz_len;
   logic [31:0] gz_word;
   logic        gz_after_good;
   logic        gz_dropping;

   // reflected crc-32, inverted on the way in and out
   function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = (crc ^ 32'hFFFF_FFFF) ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
         c = (c >> 1) ^ (GZ_CRC_POLY & {32{c[0]}});
      return c ^ 32'hFFFF_FFFF;
   endfunction

   function automatic void clear_parser();
      gz_phase      = PH_MAGIC1;
      gz_idx        = '0;
      gz_flags      = '0;
      gz_extra_left = '0;
      gz_crc        = '0;
      gz_len        = '0;
      gz_word       = '0;
      gz_after_good = 1'b0;
      gz_dropping   = 1'b0;
   endfunction

   function automatic void start_body();
      gz_phase      = PH_BODY;
      gz_after_good = 1'b0;
      gz_crc        = '0;
      gz_len        = '0;
   endfunction

   // first optional header field at or after the given phase
   function automatic void next_field(input logic [3:0] from);
      gz_idx = '0;
      if (from <= PH_XLEN && (gz_flags & GZ_FEXTRA) != 0) begin
         gz_phase = PH_XLEN;
         gz_word  = '0;
      end else if (from <= PH_NAME && (gz_flags & GZ_FNAME) != 0) begin
         gz_phase = PH_NAME;
      end else if (from <= PH_COMMENT && (gz_flags & GZ_FCOMMENT) != 0) begin
         gz_phase = PH_COMMENT;
      end else if (from <= PH_HCRC && (gz_flags & GZ_FHCRC) != 0) begin
         gz_phase = PH_HCRC;
      end else begin
         start_body();
      end
   endfunction

   function automatic logic [3:0] fatal_status(input logic [3:0] code);
      logic [3:0] s;
      s = gz_after_good ? ST_TRAILING : code;
      gz_dropping   = 1'b1;
      gz_after_good = 1'b0;
      return s;
   endfunction

   function automatic result_type parse_gzip_byte(input logic [1:0] act, input logic [7:0] b);
      result_type r;
      r = '0;
      if (act == ACT_EOF) begin
         if (!gz_dropping && gz_phase != PH_MAGIC1)
            r.status = fatal_status(ST_EARLY_EOF);
         clear_parser();
      end else if (gz_dropping) begin
         // everything dropped until end of input
      end else if (act == ACT_DATA) begin
         if (gz_phase == PH_BODY) begin
            gz_crc      = crc32_next(gz_crc, b);
            gz_len      = gz_len + 32'd1;
            r.out_valid = 1'b1;
            r.out_byte  = b;
         end
      end else if (act == ACT_BODY_END) begin
         if (gz_phase == PH_BODY) begin
            gz_phase = PH_TRAILER;
            gz_idx   = '0;
            gz_word  = '0;
         end
      end else begin
         case (gz_phase)
            PH_MAGIC1: begin
               if (b != GZ_MAGIC1) r.status = fatal_status(ST_BAD_MAGIC);
               else gz_phase = PH_MAGIC2;
            end
            PH_MAGIC2: begin
               if (b != GZ_MAGIC2) r.status = fatal_status(ST_BAD_MAGIC);
               else gz_phase = PH_METHOD;
            end
            PH_METHOD: begin
               if (b != GZ_DEFLATE) r.status = fatal_status(ST_BAD_METHOD);
               else gz_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
               gz_flags = b;
               if ((b & ~GZ_FKNOWN) != 0) r.status = ST_RSVD_FLAGS;
               gz_phase = PH_MTIME;
               gz_idx   = '0;
               gz_word  = '0;
            end
            PH_MTIME: begin
               gz_word = gz_word | ({24'd0, b} << (8 * gz_idx[1:0]));
               if (gz_idx[1:0] == 2'd3) begin
                  r.mtime_valid = 1'b1;
                  r.mtime_value = gz_word;
                  gz_phase      = PH_XFL;
                  gz_idx        = '0;
               end else begin
                  gz_idx = gz_idx + 3'd1;
               end
            end
            PH_XFL: gz_phase = PH_OS;
            PH_OS: next_field(PH_XLEN);
            PH_XLEN: begin
               if (gz_idx == 0) begin
                  gz_extra_left = {8'd0, b};
                  gz_idx        = 3'd1;
               end else begin
                  gz_extra_left = gz_extra_left | {b, 8'd0};
                  gz_idx        = '0;
                  if (gz_extra_left != 0) gz_phase = PH_EXTRA;
                  else next_field(PH_NAME);
               end
            end
            PH_EXTRA: begin
               gz_extra_left = gz_extra_left - 16'd1;
               if (gz_extra_left == 0) next_field(PH_NAME);
            end
            PH_NAME: begin
               if (b == 0) begin
                  next_field(PH_COMMENT);
               end else begin
                  r.name_valid = 1'b1;
                  r.name_char  = b;
               end
            end
            PH_COMMENT: begin
               if (b == 0) next_field(PH_HCRC);
            end
            PH_HCRC: begin
               // header crc is skipped, never checked
               if (gz_idx == 0) begin
                  gz_idx = 3'd1;
               end else begin
                  gz_idx = '0;
                  start_body();
               end
            end
            PH_TRAILER: begin
               gz_word = gz_word | ({24'd0, b} << (8 * gz_idx[1:0]));
               if (gz_idx == 3'd3) begin
                  if (gz_word != gz_crc) begin
                     r.status = fatal_status(ST_CRC_ERR);
                  end else begin
                     gz_word = '0;
                     gz_idx  = 3'd4;
                  end
               end else if (gz_idx == 3'd7) begin
                  if (gz_word != gz_len) begin
                     r.status = fatal_status(ST_LEN_ERR);
                  end else begin
                     r.status      = ST_MEMBER_OK;
                     gz_after_good = 1'b1;
                     gz_phase      = PH_MAGIC1;
                     gz_idx        = '0;
                     gz_word       = '0;
                  end
               end else begin
                  gz_idx = gz_idx + 3'd1;
               end
            end
            default: begin
               // container bytes inside the body belong to the inflate core
            end
         endcase
      end
      return r;
   endfunction

   function automatic void put_item(input logic [1:0] act, input logic [7:0] b);
      stream_item_type it;
      it.action    = act;
      it.data_byte = b;
      it.hold      = 1'b0;
      stream_items.push_back(it);
   endfunction

   // container byte of a member, now and then preceded by a misplaced action
   function automatic void put_container(input logic [7:0] b);
      stream_item_type it;
      it.hold = 1'b0;
      if ($urandom_range(0, 39) == 0) begin
         it.action    = $urandom_range(0, 1) ? ACT_DATA : ACT_BODY_END;
         it.data_byte = 8'($urandom);
         member_buf.push_back(it);
      end
      it.action    = ACT_CONTAINER;
      it.data_byte = b;
      member_buf.push_back(it);
   endfunction

   function automatic void add_member(input member_fault_type fault);
      stream_item_type it;
      logic [7:0]   flags;
      logic [7:0]   hdr0, hdr1, hdr2;
      logic [15:0]  xlen;
      logic [31:0]  crc, len;
      int unsigned  pick, nbody, cut;
      member_buf.delete();
      it.hold = 1'b0;
      hdr0 = (fault == FLT_MAGIC1) ? GZ_MAGIC1 ^ 8'($urandom_range(1, 255)) : GZ_MAGIC1;
      hdr1 = (fault == FLT_MAGIC2) ? GZ_MAGIC2 ^ 8'($urandom_range(1, 255)) : GZ_MAGIC2;
      hdr2 = (fault == FLT_METHOD) ? GZ_DEFLATE ^ 8'($urandom_range(1, 255)) : GZ_DEFLATE;
      flags = 8'($urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) flags = flags | 8'($urandom_range(1, 7) << 5);
      put_container(hdr0);
      put_container(hdr1);
      put_container(hdr2);
      put_container(flags);
      repeat (6) put_container(8'($urandom));   // mtime, xfl, os
      if ((flags & GZ_FEXTRA) != 0) begin
         pick = $urandom_range(0, 79);
         if (pick == 0) xlen = 16'($urandom_range(256, 400));
         else if (pick < 16) xlen = '0;
         else xlen = 16'($urandom_range(1, 8));
         put_container(xlen[7:0]);
         put_container(xlen[15:8]);
         repeat (xlen) put_container(8'($urandom));
      end
      if ((flags & GZ_FNAME) != 0) begin
         repeat ($urandom_range(0, 6)) put_container(8'($urandom_range(1, 255)));
         put_container(8'd0);
      end
      if ((flags & GZ_FCOMMENT) != 0) begin
         repeat ($urandom_range(0, 6)) put_container(8'($urandom_range(1, 255)));
         put_container(8'd0);
      end
      if ((flags & GZ_FHCRC) != 0) repeat (2) put_container(8'($urandom));
      nbody = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 120) : $urandom_range(0, 16);
      crc = '0;
      len = '0;
      for (int i = 0; i < nbody; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            it.action    = ACT_CONTAINER;
            it.data_byte = 8'($urandom);
            member_buf.push_back(it);
         end
         it.action    = ACT_DATA;
         it.data_byte = 8'($urandom);
         crc = crc32_next(crc, it.data_byte);
         len = len + 32'd1;
         member_buf.push_back(it);
      end
      it.action    = ACT_BODY_END;
      it.data_byte = 8'($urandom);
      member_buf.push_back(it);
      if (fault == FLT_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      if (fault == FLT_LENGTH) len = len ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) put_container(crc[8*i +: 8]);
      for (int i = 0; i < 4; i++) put_container(len[8*i +: 8]);
      if (fault == FLT_CUT) begin
         cut = $urandom_range(1, member_buf.size() - 1);
         member_buf = member_buf[0:cut-1];
      end
      foreach (member_buf[i]) stream_items.push_back(member_buf[i]);
   endfunction

   function automatic void add_stream();
      member_fault_type fault;
      int unsigned      nmem;
      fault = FLT_NONE;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any action, any byte
         repeat ($urandom_range(1, 12)) put_item(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
         nmem = $urandom_range(1, 3);
         for (int m = 0; m < nmem; m++) begin
            fault = ($urandom_range(0, 99) < 82) ? FLT_NONE
                                                 : member_fault_type'($urandom_range(1, 6));
            add_member(fault);
            if (fault != FLT_NONE) begin
               if (fault != FLT_CUT)
                  repeat ($urandom_range(0, 3)) put_item(2'($urandom_range(0, 2)), 8'($urandom));
               break;
            end
         end
         if (fault == FLT_NONE && $urandom_range(0, 3) == 0)
            put_item(ACT_CONTAINER, 8'($urandom));   // trailing garbage
      end
      put_item(ACT_EOF, 8'($urandom));
   endfunction

   function automatic void note_error(input string msg);
      if (err_count < MAX_REPORTS) $display("%s", msg);
      err_count++;
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      stream_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_taken) begin
            if (stream_items.size() != 0 && !(stream_items[0].hold && results_due.size() != 0)
                && (steady || $urandom_range(0, 99) >= 10)) begin
               nxt = stream_items.pop_front();
               req_if.valid     <= 1'b1;
               req_if.action    <= nxt.action;
               req_if.data_byte <= nxt.data_byte;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   // monitor, model and watchdog on the rising edge
   always @(posedge clock) begin
      result_type got, want;
      logic       req_fire, rsp_fire;
      if (reset) begin
         clear_parser();
         results_due.delete();
         req_taken   <= 1'b0;
         drained     <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         rsp_fire = rsp_if.valid && rsp_if.ready;
         cyc <= cyc + 1;
         if (rsp_fire) begin
            got.status      = rsp_if.status;
            got.mtime_valid = rsp_if.mtime_valid;
            got.mtime_value = rsp_if.mtime_value;
            got.name_valid  = rsp_if.name_valid;
            got.name_char   = rsp_if.name_char;
            got.out_valid   = rsp_if.out_valid;
            got.out_byte    = rsp_if.out_byte;
            if (results_due.size() == 0) begin
               note_error($sformatf("result %0d: unexpected transaction, status %0d",
                                    results_seen, got.status));
            end else begin
               want = results_due.pop_front();
               if (got.status !== want.status || got.mtime_valid !== want.mtime_valid
                   || got.mtime_value !== want.mtime_value || got.name_valid !== want.name_valid
                   || got.name_char !== want.name_char || got.out_valid !== want.out_valid
                   || got.out_byte !== want.out_byte)
                  note_error($sformatf({"result %0d: expected status %0d mtime %0b/%h ",
                                        "name %0b/%h out %0b/%h, got status %0d mtime %0b/%h ",
                                        "name %0b/%h out %0b/%h"}, results_seen,
                                       want.status, want.mtime_valid, want.mtime_value,
                                       want.name_valid, want.name_char, want.out_valid,
                                       want.out_byte, got.status, got.mtime_valid,
                                       got.mtime_value, got.name_valid, got.name_char,
                                       got.out_valid, got.out_byte));
            end
            results_seen++;
         end
         if (req_fire) results_due.push_back(parse_gzip_byte(req_if.action, req_if.data_byte));
         req_taken <= req_fire;
         drained   <= stream_items.size() == 0 && (!req_if.valid || req_if.ready)
                      && results_due.size() == 0;
         if (req_fire || rsp_fire) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [31:0]  crc;
      int unsigned  first;
      int unsigned  n_streams;

      // every flag incl. reserved bits, zero-length extra, empty name and comment,
      // skipped header crc, one 0xff data byte, good trailer
      put_item(ACT_CONTAINER, GZ_MAGIC1);
      put_item(ACT_CONTAINER, GZ_MAGIC2);
      put_item(ACT_CONTAINER, GZ_DEFLATE);
      put_item(ACT_CONTAINER, 8'hFF);
      put_item(ACT_CONTAINER, 8'h00);
      put_item(ACT_CONTAINER, 8'hFF);
      put_item(ACT_CONTAINER, 8'h80);
      put_item(ACT_CONTAINER, 8'h7F);
      put_item(ACT_CONTAINER, 8'h00);
      put_item(ACT_CONTAINER, 8'hFF);
      put_item(ACT_CONTAINER, 8'h00);
      put_item(ACT_CONTAINER, 8'h00);
      put_item(ACT_CONTAINER, 8'h00);
      put_item(ACT_CONTAINER, 8'h00);
      put_item(ACT_CONTAINER, 8'h12);
      put_item(ACT_CONTAINER, 8'h34);
      put_item(ACT_DATA, 8'hFF);
      put_item(ACT_BODY_END, 8'h00);
      crc = crc32_next(32'd0, 8'hFF);
      for (int i = 0; i < 4; i++) put_item(ACT_CONTAINER, crc[8*i +: 8]);
      put_item(ACT_CONTAINER, 8'd1);
      repeat (3) put_item(ACT_CONTAINER, 8'd0);
      put_item(ACT_EOF, 8'hFF);

      n_streams = 0;
      while (stream_items.size() < STREAM_ITEMS) begin
         first = stream_items.size();
         add_stream();
         // sender waits for every outstanding result before this stream
         if (n_streams == 2 || $urandom_range(0, 24) == 0) stream_items[first].hold = 1'b1;
         n_streams++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (!drained);
      repeat (8) @(negedge clock);

      if (err_count == 0 && results_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/gzhc_pkg.sv
design/gzhc_if.sv
design/gzhc_step.sv
design/gzip_member_header_trailer_check.sv
design/gzhc_checker.sv
tb/gzip_member_header_trailer_check_tb.sv
